// ===== design/p1305_pkg.sv =====
`default_nettype none
package p1305_pkg;
	localparam logic [63:0] CLAMP_LOW  = 64'h0ffffffc0fffffff;
	localparam logic [63:0] CLAMP_HIGH = 64'h0ffffffc0ffffffc;

	localparam logic [1:0] REG_R_LOW  = 2'd0;
	localparam logic [1:0] REG_R_HIGH = 2'd1;
	localparam logic [1:0] REG_S_LOW  = 2'd2;
	localparam logic [1:0] REG_S_HIGH = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SETTLE,
		ST_FINAL,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic mac;
		logic settle;
		logic finish;
		logic [2:0] col;
		logic [2:0] row;
	} cmd_t;

	typedef struct packed {
		logic absorb;
		logic last;
	} sts_t;
endpackage
`default_nettype wire

// ===== design/poly1305_mac_core.sv =====
`default_nettype none
// Poly1305 authenticator. Write the 32-byte key through the config port while idle
// (indexes 0..3: r low, r high, s low, s high). Each non-empty block word is an issue
// step, 25 limb products on one shared 26x29 multiplier and 3 carry passes; a last
// word adds a final reduction step that loads the tag register.
// The tag word stays on tag_low/tag_high until taken; no new word is accepted before.
module poly1305_mac_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_idx,
	input  wire logic [63:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [63:0] block_low,
	input  wire logic [63:0] block_high,
	input  wire logic [4:0]  block_bytes,
	input  wire logic        last,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [63:0]      tag_low,
	output logic [63:0]      tag_high
);
	import p1305_pkg::*;

	cmd_t cmd;
	sts_t sts;

	p1305_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
	);

	p1305_dp u_dp (
		.clk, .arst_n, .cfg_we, .cfg_idx, .cfg_data, .block_low, .block_high,
		.block_bytes, .last, .cmd, .sts, .tag_low, .tag_high
	);
endmodule
`default_nettype wire

// ===== design/p1305_ctrl.sv =====
`default_nettype none
module p1305_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  wire logic         out_ready,
	input  wire p1305_pkg::sts_t sts,
	output p1305_pkg::cmd_t   cmd
);
	import p1305_pkg::*;

	state_t state_q, state_d;
	logic [2:0] col_q, col_d, row_q, row_d;
	logic [1:0] pass_q, pass_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			col_q <= '0;
			row_q <= '0;
			pass_q <= '0;
		end else begin
			state_q <= state_d;
			col_q <= col_d;
			row_q <= row_d;
			pass_q <= pass_d;
		end
	end

	always_comb begin
		state_d = state_q;
		col_d = col_q;
		row_d = row_q;
		pass_d = pass_q;
		cmd = '0;
		cmd.col = col_q;
		cmd.row = row_q;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					col_d = '0;
					row_d = '0;
					if (sts.absorb) state_d = ST_MUL;
					else if (sts.last) state_d = ST_FINAL;
				end
			end
			ST_MUL: begin
				cmd.mac = 1'b1;
				if (row_q == 3'd4) begin
					row_d = '0;
					if (col_q == 3'd4) begin
						pass_d = '0;
						state_d = ST_SETTLE;
					end else col_d = col_q + 3'd1;
				end else row_d = row_q + 3'd1;
			end
			ST_SETTLE: begin
				cmd.settle = 1'b1;
				pass_d = pass_q + 2'd1;
				if (pass_q == 2'd2) state_d = sts.last ? ST_FINAL : ST_IDLE;
			end
			ST_FINAL: begin
				cmd.finish = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

// ===== design/p1305_dp.sv =====
`default_nettype none
module p1305_dp (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_idx,
	input  wire logic [63:0] cfg_data,
	input  wire logic [63:0] block_low,
	input  wire logic [63:0] block_high,
	input  wire logic [4:0]  block_bytes,
	input  wire logic        last,
	input  wire p1305_pkg::cmd_t cmd,
	output p1305_pkg::sts_t  sts,
	output logic [63:0]      tag_low,
	output logic [63:0]      tag_high
);
	import p1305_pkg::*;

	logic [63:0] r_lo_q, r_hi_q, s_lo_q, s_hi_q;
	logic [129:0] acc_q;
	logic [25:0] h_q [5];
	logic [63:0] d_q [5];
	logic last_q;
	logic [127:0] tag_q;

	logic [4:0] nb;
	logic [129:0] msg, r_full, sum;
	logic [130:0] sum_c;
	logic [127:0] mask;
	logic [25:0] rl [5];
	logic [25:0] h_sel, r_sel;
	logic [28:0] r_mul;
	logic [2:0] dst;
	logic [54:0] prod;
	logic [63:0] d_set [5];
	logic [37:0] c;
	logic [130:0] g;
	logic [127:0] tag_sum;
	logic [129:0] h_join;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_lo_q <= '0; r_hi_q <= '0; s_lo_q <= '0; s_hi_q <= '0;
			acc_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_R_LOW:  r_lo_q <= cfg_data;
					REG_R_HIGH: r_hi_q <= cfg_data;
					REG_S_LOW:  s_lo_q <= cfg_data;
					REG_S_HIGH: s_hi_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.settle) acc_q <= {d_set[4][25:0], d_set[3][25:0], d_set[2][25:0],
				d_set[1][25:0], d_set[0][25:0]};
			if (cmd.finish && last_q) acc_q <= '0;
		end
	end

	always_comb begin
		nb = (block_bytes > 5'd16) ? 5'd16 : block_bytes;
		mask = (128'd1 << {nb[3:0], 3'b000}) - 128'd1;
		if (nb[4]) msg = {2'b01, block_high, block_low};
		else msg = {2'b00, ({block_high, block_low} & mask)} | (130'd1 << {nb[3:0], 3'b000});
		// fold a carry past 2^130 back in as 5
		sum_c = {1'b0, acc_q} + {1'b0, msg};
		sum = sum_c[129:0] + (sum_c[130] ? 130'd5 : 130'd0);
		sts.absorb = (nb != 5'd0);
		sts.last = cmd.load ? last : last_q;
		r_full = {2'b00, r_hi_q & CLAMP_HIGH, r_lo_q & CLAMP_LOW};
		for (int i = 0; i < 5; i++) rl[i] = r_full[26*i +: 26];
		h_sel = h_q[cmd.row];
		r_sel = 26'd0;
		// column col of output; h index row times r index (col-row) mod 5
		if (cmd.col >= cmd.row) begin
			r_sel = rl[cmd.col - cmd.row];
			r_mul = {3'b000, r_sel};
		end else begin
			r_sel = rl[3'd5 + cmd.col - cmd.row];
			r_mul = {3'b000, r_sel} + {1'b0, r_sel, 2'b00};
		end
		dst = cmd.col;
		prod = {26'd0, h_sel} * {26'd0, r_mul};
		c = '0;
		for (int i = 0; i < 5; i++) begin
			d_set[i] = d_q[i] + {26'd0, c};
			c = d_set[i][63:26];
			d_set[i] = {38'd0, d_set[i][25:0]};
		end
		d_set[0] = d_set[0] + {24'd0, c, 2'b00} + {26'd0, c};
		h_join = {h_q[4], h_q[3], h_q[2], h_q[1], h_q[0]};
		g = {1'b0, h_join} + 131'd5;
		tag_sum = (g[130] ? g[127:0] : h_join[127:0]) + {s_hi_q, s_lo_q};
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			last_q <= last;
			for (int i = 0; i < 5; i++) begin
				h_q[i] <= sts.absorb ? sum[26*i +: 26] : acc_q[26*i +: 26];
				d_q[i] <= '0;
			end
		end
		if (cmd.mac) d_q[dst] <= d_q[dst] + {9'd0, prod};
		if (cmd.settle) for (int i = 0; i < 5; i++) begin
			d_q[i] <= d_set[i];
			h_q[i] <= d_set[i][25:0];
		end
		if (cmd.finish) tag_q <= tag_sum;
	end

	assign tag_low = tag_q[63:0];
	assign tag_high = tag_q[127:64];
endmodule
`default_nettype wire

// ===== design/poly1305_mac_core_chk.sv =====
`default_nettype none
module poly1305_mac_core_chk (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic [4:0] block_bytes,
	input wire logic last,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [63:0] tag_low,
	input wire logic [63:0] tag_high
);
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("ready while tag pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(tag_low) && $stable(tag_high))
		else $error("tag dropped");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (block_bytes != 5'd0 || last) |=> !in_ready)
		else $error("no busy after accept");
endmodule

bind poly1305_mac_core poly1305_mac_core_chk u_chk (
	.clk, .arst_n, .in_valid, .in_ready, .block_bytes, .last, .out_valid, .out_ready,
	.tag_low, .tag_high
);
`default_nettype wire

// ===== bench/testbench.sv =====
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import p1305_pkg::*;

	localparam int STALL_LIMIT = 20000;
	localparam logic [129:0] PRIME = (130'd1 << 130) - 130'd5;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_idx = REG_R_LOW;
	logic [63:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [63:0] block_low = '0;
	logic [63:0] block_high = '0;
	logic [4:0] block_bytes = '0;
	logic last = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [63:0] tag_low;
	logic [63:0] tag_high;

	poly1305_mac_core dut (.*);

	always #10 clk = ~clk;

	logic [63:0] key_words [4];
	logic [129:0] hash_acc;
	logic [127:0] tag_queue [$];
	int errors = 0;
	int idle_cycles = 0;
	logic sink_stall_on = 1'b1;

	task automatic report(input string what);
		$display("mismatch: %s", what);
		errors++;
	endtask

	function automatic logic [129:0] mulmod(input logic [129:0] a, input logic [129:0] b);
		logic [259:0] prod;
		prod = 260'(a) * 260'(b);
		return 130'(prod % 260'(PRIME));
	endfunction

	task automatic predict_block(input logic [63:0] lo, input logic [63:0] hi,
			input logic [4:0] nbytes, input logic fin);
		int n;
		logic [127:0] msg;
		logic [129:0] m;
		logic [129:0] r;
		logic [130:0] sum;
		logic [129:0] h;
		n = nbytes > 16 ? 16 : int'(nbytes);
		msg = {hi, lo};
		if (n != 0) begin
			m = (n == 16) ? 130'(msg) : 130'(msg & ((128'd1 << (8 * n)) - 128'd1));
			m = m | (130'd1 << (8 * n));
			r = 130'({key_words[REG_R_HIGH] & CLAMP_HIGH, key_words[REG_R_LOW] & CLAMP_LOW});
			sum = 131'(hash_acc) + 131'(m);
			sum = sum % 131'(PRIME);
			hash_acc = mulmod(130'(sum), r);
		end
		if (fin) begin
			h = hash_acc % PRIME;
			tag_queue.push_back(h[127:0] + {key_words[REG_S_HIGH], key_words[REG_S_LOW]});
			hash_acc = '0;
		end
	endtask

	task automatic random_gap();
		int k;
		k = $urandom_range(0, 9);
		if (k < 4) k = 0;
		else if (k < 9) k = $urandom_range(1, 3);
		else k = $urandom_range(10, 40);
		repeat (k) @(posedge clk);
	endtask

	task automatic send_block(input logic [63:0] lo, input logic [63:0] hi,
			input logic [4:0] nbytes, input logic fin);
		random_gap();
		in_valid <= 1'b1;
		block_low <= lo;
		block_high <= hi;
		block_bytes <= nbytes;
		last <= fin;
		do @(posedge clk); while (!in_ready);
		predict_block(lo, hi, nbytes, fin);
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (tag_queue.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_key(input logic [1:0] idx, input logic [63:0] value);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= value;
		@(posedge clk);
		key_words[idx] = value;
	endtask

	task automatic load_key(input logic [63:0] k0, input logic [63:0] k1,
			input logic [63:0] k2, input logic [63:0] k3);
		drain();
		write_key(REG_R_LOW, k0);
		write_key(REG_R_HIGH, k1);
		write_key(REG_S_LOW, k2);
		write_key(REG_S_HIGH, k3);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	task automatic test_known_vector();
		load_key(64'h0103808afb0db2fd, 64'h4abff6af4149f51b,
			64'h1bf54941aff6bf4a, 64'hfdb20dfb8a800301);
		send_block(64'h6172676f74707972, 64'h6f7275465f636968, 5'd16, 1'b0);
		send_block(64'h6573655220686372, 64'h6f72472068637261, 5'd16, 1'b0);
		send_block(64'h0000000000007075, 64'h0, 5'd2, 1'b1);
	endtask

	task automatic test_extremes();
		load_key('1, '1, '1, '1);
		send_block('1, '1, 5'd16, 1'b0);
		send_block('1, '1, 5'd31, 1'b0);
		send_block('1, '1, 5'd17, 1'b1);
		send_block('0, '0, 5'd0, 1'b1);
		send_block('1, '1, 5'd7, 1'b0);
		send_block('1, '1, 5'd0, 1'b0);
		send_block('1, '1, 5'd8, 1'b0);
		send_block('1, '1, 5'd9, 1'b1);
		load_key('0, '0, '0, '0);
		send_block('1, '1, 5'd16, 1'b0);
		send_block('0, '0, 5'd1, 1'b1);
		load_key(rand64(), rand64(), rand64(), rand64());
		for (int n = 1; n <= 15; n += 2)
			send_block(rand64(), rand64(), 5'(n), n == 15);
	endtask

	task automatic test_random_messages();
		int sent;
		int len;
		sent = 0;
		while (sent < 620) begin
			if ($urandom_range(0, 7) == 0)
				load_key(rand64(), rand64(), rand64(), rand64());
			sink_stall_on = $urandom_range(0, 4) != 0;
			len = $urandom_range(0, 6);
			for (int i = 0; i < len; i++) begin
				send_block(rand64(), rand64(),
					$urandom_range(0, 9) == 0 ? 5'($urandom_range(0, 31)) : 5'd16, 1'b0);
				sent++;
			end
			send_block(rand64(), rand64(), 5'($urandom_range(0, 31)), 1'b1);
			sent++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (sink_stall_on)
				out_ready <= $urandom_range(0, 9) < 6 ? 1'b1 :
					($urandom_range(0, 19) == 0 ? 1'b0 : 1'b0);
			else
				out_ready <= 1'b1;
			if (out_valid && out_ready) begin
				if (tag_queue.size() == 0) begin
					report("tag with none expected");
				end else begin
					if (tag_low !== tag_queue[0][63:0])
						report($sformatf("tag_low %h expected %h", tag_low, tag_queue[0][63:0]));
					if (tag_high !== tag_queue[0][127:64])
						report($sformatf("tag_high %h expected %h", tag_high,
							tag_queue[0][127:64]));
					void'(tag_queue.pop_front());
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		for (int i = 0; i < 4; i++) key_words[i] = '0;
		hash_acc = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_known_vector();
		test_extremes();
		test_random_messages();
		drain();
		if (errors == 0 && tag_queue.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
`default_nettype wire
